FILE: sv/pats_pkg.sv
// Shared types, codes and constants of the priority aging task scheduler.
`default_nettype none

package pats_pkg;

  localparam int unsigned MaxTasksDef = 16;

  localparam logic signed [7:0] PrioMin    = -8'sd20;
  localparam logic signed [7:0] PrioMax    = 8'sd20;
  localparam logic [7:0]        QuantumRst = 8'd20;
  localparam logic signed [5:0] FloorRst   = -6'sd20;
  localparam logic [15:0]       FirstId    = 16'd2;

  typedef enum logic [2:0] {
    ModeAdd    = 3'd0,
    ModeSet    = 3'd1,
    ModeRemove = 3'd2,
    ModeSched  = 3'd3,
    ModeTick   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadPrio  = 3'd1,
    StFull     = 3'd2,
    StNotFound = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef enum logic {
    CfgQuantum = 1'b0,
    CfgFloor   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]       tid;
    logic signed [5:0] prio;
    logic signed [5:0] aging;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic              take;
    logic signed [6:0] sum;
    logic signed [5:0] aged;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: sv/pats_table.sv
// Task table memory: one write port, one registered read port.
`default_nettype none

module pats_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 28
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/pats_alu.sv
// Shared entry unit: id match, priority sum, best compare and aging step.
`default_nettype none

module pats_alu (
  input  wire pats_pkg::entry_t          ent_i,
  input  wire logic [15:0]               tid_i,
  input  wire logic signed [5:0]         floor_i,
  input  wire logic signed [6:0]         best_sum_i,
  input  wire logic                      first_i,
  output pats_pkg::alu_res_t             res_o
);

  import pats_pkg::*;

  logic signed [6:0] sp;
  logic signed [6:0] sa;

  assign sp = $signed({ent_i.prio[5], ent_i.prio});
  assign sa = $signed({ent_i.aging[5], ent_i.aging});

  always_comb begin
    res_o.hit  = (ent_i.tid == tid_i);
    res_o.sum  = sp + sa;
    res_o.take = first_i || (res_o.sum < best_sum_i);
    res_o.aged = ($signed(ent_i.aging) > floor_i) ? ($signed(ent_i.aging) - 6'sd1)
                                                  : $signed(ent_i.aging);
  end

endmodule

`default_nettype wire

FILE: sv/priority_aging_task_scheduler.sv
// Priority scheduler with aging over a packed, insertion-ordered task table.
// Each request walks the table one entry per cycle through the single read port of
// the table memory. Add, set priority, tick without dispatch and unused modes make
// one walk; schedule and a tick that expires the quantum run a second walk when the
// table holds tasks, and a remove that finds its task walks the entries after it. The
// block takes one request at a time and accepts the next one while a result still
// waits in the output register. The table needs no clearing after reset: a fill
// count marks the valid entries, so the block is ready right after reset.
`default_nettype none

module priority_aging_task_scheduler #(
  parameter int unsigned MaxTasks = pats_pkg::MaxTasksDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [2:0]                       mode_i,
  input  wire logic [15:0]                      task_id_i,
  input  wire logic signed [7:0]                priority_req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [2:0]                            status_o,
  output logic [15:0]                           chosen_task_o,
  output logic                                  chosen_valid_o,
  output logic signed [5:0]                     static_priority_o,
  output logic [31:0]                           system_time_o,
  output logic [$clog2(MaxTasks+1)-1:0]         task_count_o,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [7:0]                       cfg_data_i
);

  import pats_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam int unsigned EntW = $bits(entry_t);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SFind = 4'b0010,
    SExec = 4'b0100,
    SDone = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [2:0]        mode_q, mode_d;
  logic [15:0]       tid_q, tid_d;
  logic signed [7:0] req_q, req_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [15:0]       next_q, next_d;
  logic [7:0]        ql_q, ql_d;
  logic              run_q, run_d;
  logic [15:0]       run_tid_q, run_tid_d;
  logic [31:0]       tick_q, tick_d;
  logic [7:0]        quantum_q;
  logic signed [5:0] floor_q;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              rdv_q, rdv_d;
  logic [IdxW-1:0]   rdi_q, rdi_d;
  logic              found_q, found_d;
  entry_t            fent_q, fent_d;
  logic [IdxW-1:0]   fidx_q, fidx_d;
  entry_t            best_q, best_d;
  logic [IdxW-1:0]   bidx_q, bidx_d;
  logic signed [6:0] bsum_q, bsum_d;
  logic              sched_q, sched_d;
  logic [2:0]        rstat_q, rstat_d;
  logic [15:0]       rchosen_q, rchosen_d;
  logic              rcvalid_q, rcvalid_d;
  logic signed [5:0] rsprio_q, rsprio_d;
  logic              ovalid_q, ovalid_d;
  logic [2:0]        ostat_q, ostat_d;
  logic [15:0]       ochosen_q, ochosen_d;
  logic              ocvalid_q, ocvalid_d;
  logic signed [5:0] osprio_q, osprio_d;
  logic [31:0]       otime_q, otime_d;
  logic [CntW-1:0]   ocount_q, ocount_d;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;
  logic [EntW-1:0]   mem_rdata;
  entry_t            rd_ent;
  alu_res_t          alu;
  logic              scan_more;
  logic              pass_end;
  logic              go_sched;
  logic              bad_prio;
  logic signed [5:0] sprio_found;

  assign rd_ent = entry_t'(mem_rdata);

  pats_table #(
    .Depth(MaxTasks),
    .Width(EntW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(mem_rdata)
  );

  pats_alu u_alu (
    .ent_i     (rd_ent),
    .tid_i     (tid_q),
    .floor_i   (floor_q),
    .best_sum_i(bsum_q),
    .first_i   (rdi_q == '0),
    .res_o     (alu)
  );

  assign scan_more   = (scan_q < count_q);
  assign pass_end    = !scan_more && !rdv_q;
  assign bad_prio    = (req_q < PrioMin) || (req_q > PrioMax);
  assign sprio_found = found_q ? fent_q.prio : 6'sd0;
  assign in_ready_o  = (state_q == SIdle);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    tid_d     = tid_q;
    req_d     = req_q;
    count_d   = count_q;
    next_d    = next_q;
    ql_d      = ql_q;
    run_d     = run_q;
    run_tid_d = run_tid_q;
    tick_d    = tick_q;
    scan_d    = scan_q;
    rdv_d     = 1'b0;
    rdi_d     = rdi_q;
    found_d   = found_q;
    fent_d    = fent_q;
    fidx_d    = fidx_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    bsum_d    = bsum_q;
    sched_d   = sched_q;
    rstat_d   = rstat_q;
    rchosen_d = rchosen_q;
    rcvalid_d = rcvalid_q;
    rsprio_d  = rsprio_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ostat_d   = ostat_q;
    ochosen_d = ochosen_q;
    ocvalid_d = ocvalid_q;
    osprio_d  = osprio_q;
    otime_d   = otime_q;
    ocount_d  = ocount_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    go_sched  = 1'b0;

    if ((state_q == SFind || state_q == SExec) && scan_more) begin
      scan_d = scan_q + CntW'(1);
      rdv_d  = 1'b1;
      rdi_d  = scan_q[IdxW-1:0];
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          tid_d   = task_id_i;
          req_d   = priority_req_i;
          scan_d  = '0;
          found_d = 1'b0;
          state_d = SFind;
        end
      end
      SFind: begin
        if (rdv_q && alu.hit && !found_q) begin
          found_d = 1'b1;
          fent_d  = rd_ent;
          fidx_d  = rdi_q;
        end
        if (pass_end) begin
          rstat_d   = StOk;
          rchosen_d = '0;
          rcvalid_d = 1'b0;
          rsprio_d  = sprio_found;
          state_d   = SDone;
          unique case (mode_q)
            ModeAdd: begin
              if (count_q >= CntW'(MaxTasks) || next_q < FirstId) begin
                rstat_d = StFull;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IdxW-1:0];
                mem_wdata = '{tid: next_q, prio: 6'sd0, aging: 6'sd0};
                count_d   = count_q + CntW'(1);
                next_d    = next_q + 16'd1;
                rchosen_d = next_q;
                rcvalid_d = 1'b1;
                rsprio_d  = 6'sd0;
              end
            end
            ModeSet: begin
              if (bad_prio) begin
                rstat_d = StBadPrio;
              end else if (found_q) begin
                mem_we    = 1'b1;
                mem_waddr = fidx_q;
                mem_wdata = '{tid: fent_q.tid, prio: req_q[5:0], aging: fent_q.aging};
                rsprio_d  = req_q[5:0];
              end else begin
                rstat_d = StNotFound;
              end
            end
            ModeRemove: begin
              if (!found_q) begin
                rstat_d = StNotFound;
              end else begin
                rsprio_d = 6'sd0;
                scan_d   = CntW'(fidx_q) + CntW'(1);
                sched_d  = 1'b0;
                state_d  = SExec;
              end
            end
            ModeSched: begin
              go_sched = 1'b1;
            end
            ModeTick: begin
              tick_d = tick_q + 32'd1;
              if (run_q) begin
                if (ql_q > 8'd1) begin
                  ql_d = ql_q - 8'd1;
                end else begin
                  ql_d     = 8'd0;
                  go_sched = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (go_sched) begin
            if (count_q == '0) begin
              run_d   = 1'b0;
              ql_d    = 8'd0;
              rstat_d = StEmpty;
            end else begin
              scan_d  = '0;
              sched_d = 1'b1;
              state_d = SExec;
            end
          end
        end
      end
      SExec: begin
        if (rdv_q) begin
          mem_we = 1'b1;
          if (sched_q) begin
            mem_waddr = rdi_q;
            mem_wdata = '{tid: rd_ent.tid, prio: rd_ent.prio, aging: alu.aged};
            if (alu.take) begin
              best_d = rd_ent;
              bidx_d = rdi_q;
              bsum_d = alu.sum;
            end
          end else begin
            mem_waddr = rdi_q - IdxW'(1);
            mem_wdata = rd_ent;
          end
        end
        if (pass_end) begin
          state_d = SDone;
          if (sched_q) begin
            mem_we    = 1'b1;
            mem_waddr = bidx_q;
            mem_wdata = '{tid: best_q.tid, prio: best_q.prio, aging: 6'sd0};
            ql_d      = quantum_q;
            run_d     = 1'b1;
            run_tid_d = best_q.tid;
            rchosen_d = best_q.tid;
            rcvalid_d = 1'b1;
          end else begin
            count_d = count_q - CntW'(1);
            if (run_q && run_tid_q == tid_q) begin
              run_d = 1'b0;
              ql_d  = 8'd0;
            end
          end
        end
      end
      SDone: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d  = 1'b1;
          ostat_d   = rstat_q;
          ochosen_d = rchosen_q;
          ocvalid_d = rcvalid_q;
          osprio_d  = rsprio_q;
          otime_d   = tick_q;
          ocount_d  = count_q;
          state_d   = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      next_q    <= FirstId;
      ql_q      <= 8'd0;
      run_q     <= 1'b0;
      run_tid_q <= 16'd0;
      tick_q    <= 32'd0;
      quantum_q <= QuantumRst;
      floor_q   <= FloorRst;
      rdv_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_q    <= next_d;
      ql_q      <= ql_d;
      run_q     <= run_d;
      run_tid_q <= run_tid_d;
      tick_q    <= tick_d;
      rdv_q     <= rdv_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgQuantum: quantum_q <= cfg_data_i;
          CfgFloor:   floor_q   <= cfg_data_i[5:0];
          default:    quantum_q <= quantum_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    tid_q     <= tid_d;
    req_q     <= req_d;
    scan_q    <= scan_d;
    rdi_q     <= rdi_d;
    found_q   <= found_d;
    fent_q    <= fent_d;
    fidx_q    <= fidx_d;
    best_q    <= best_d;
    bidx_q    <= bidx_d;
    bsum_q    <= bsum_d;
    sched_q   <= sched_d;
    rstat_q   <= rstat_d;
    rchosen_q <= rchosen_d;
    rcvalid_q <= rcvalid_d;
    rsprio_q  <= rsprio_d;
    ostat_q   <= ostat_d;
    ochosen_q <= ochosen_d;
    ocvalid_q <= ocvalid_d;
    osprio_q  <= osprio_d;
    otime_q   <= otime_d;
    ocount_q  <= ocount_d;
  end

  assign out_valid_o       = ovalid_q;
  assign status_o          = ostat_q;
  assign chosen_task_o     = ochosen_q;
  assign chosen_valid_o    = ocvalid_q;
  assign static_priority_o = osprio_q;
  assign system_time_o     = otime_q;
  assign task_count_o      = ocount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTasks))
    else $error("task count above table depth");

  a_run_has_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (count_q != '0))
    else $error("running with an empty table");

  a_chosen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chosen_valid_o) |-> (status_o == StOk))
    else $error("chosen task with error status");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule

`default_nettype wire
